// ===== design/scan_quad_ray_cast_defines.svh =====
// ----------------------------------------------------------------------------
// scan_quad_ray_cast assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCAN_QUAD_RAY_CAST_DEFINES_SVH
`define SCAN_QUAD_RAY_CAST_DEFINES_SVH

// condition holds at every clock edge
`define SQRC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition in one cycle implies a result in the next
`define SQRC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/sqrc_pkg.sv =====
// ----------------------------------------------------------------------------
// sqrc_pkg
// Shared constants and types of the quadrilateral ray cast pipeline.
// ----------------------------------------------------------------------------
package sqrc_pkg;

	localparam int POS_W      = 32;
	localparam int DIR_W      = 18;
	localparam int RANGE_W    = 32;
	localparam int CORNER_W   = 2 * POS_W;
	localparam int FRAC_BITS  = 16;
	localparam int DIV_STEPS  = 32;
	localparam int EDGE_LAT   = 3 + DIV_STEPS;
	localparam int IN_DATA_W  = 200;
	localparam int OUT_DATA_W = 32;

	// input tdata layout
	localparam int SX_LO  = 0;
	localparam int SY_LO  = 32;
	localparam int SZ_LO  = 64;
	localparam int RC_LO  = 96;
	localparam int RS_LO  = 114;
	localparam int BC_LO  = 132;
	localparam int BS_LO  = 150;
	localparam int RNG_LO = 168;

	localparam logic FUNC_POSE = 1'b0;
	localparam logic FUNC_BEAM = 1'b1;

	localparam logic signed [POS_W:0] HEIGHT_WIN = 33'sd65536;

	typedef struct packed {
		logic                 hit;
		logic [RANGE_W-1:0]   span;
	} sqrc_hit_t;

endpackage

// ===== design/sqrc_pose.sv =====
// ----------------------------------------------------------------------------
// sqrc_pose
// Three-stage transform of the world corners into the sensor frame.
// ----------------------------------------------------------------------------
module sqrc_pose #(
	parameter int NUM_CORNERS = 4,
	parameter int COORD_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [sqrc_pkg::CORNER_W-1:0]       corners [NUM_CORNERS],
	input  logic signed [sqrc_pkg::POS_W-1:0]   obj_height,
	input  logic signed [sqrc_pkg::POS_W-1:0]   sensor_x,
	input  logic signed [sqrc_pkg::POS_W-1:0]   sensor_y,
	input  logic signed [sqrc_pkg::POS_W-1:0]   sensor_z,
	input  logic signed [sqrc_pkg::DIR_W-1:0]   rot_cos,
	input  logic signed [sqrc_pkg::DIR_W-1:0]   rot_sin,
	output logic signed [COORD_BITS-1:0]        loc_x_s3 [NUM_CORNERS],
	output logic signed [COORD_BITS-1:0]        loc_y_s3 [NUM_CORNERS],
	output logic                                height_ok_s3
);
	import sqrc_pkg::*;

	localparam int DW  = POS_W + 1;
	localparam int PW  = DW + DIR_W;
	localparam int SMW = PW + 1;
	localparam int SHW = SMW - FRAC_BITS;
	localparam int EW  = (SHW > COORD_BITS ? SHW : COORD_BITS) + 1;
	localparam logic signed [EW-1:0] CMAX = EW'((65'sd1 <<< (COORD_BITS - 1)) - 65'sd1);
	localparam logic signed [EW-1:0] CMIN = ~CMAX;

	logic signed [DIR_W-1:0] rc_s1, rs_s1;
	logic                    hok_s1, hok_s2;
	logic signed [POS_W:0]   dz;

	assign dz = $signed({obj_height[POS_W-1], obj_height}) - $signed({sensor_z[POS_W-1], sensor_z});

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s1        <= rot_cos;
			rs_s1        <= rot_sin;
			hok_s1       <= (dz <= HEIGHT_WIN) && (dz >= -HEIGHT_WIN);
			hok_s2       <= hok_s1;
			height_ok_s3 <= hok_s2;
		end
	end

	for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_corner
		logic signed [DW-1:0]  dx_s1, dy_s1;
		logic signed [PW-1:0]  cdx_s2, sdy_s2, sdx_s2, cdy_s2;
		logic signed [SMW-1:0] sx, sy;
		logic signed [SHW-1:0] fx, fy;
		logic signed [EW-1:0]  ex, ey;
		logic signed [POS_W-1:0] wx, wy;

		assign wx = corners[i][CORNER_W-1:POS_W];
		assign wy = corners[i][POS_W-1:0];

		always_ff @(posedge clk) begin
			if (en) begin
				dx_s1  <= $signed({wx[POS_W-1], wx}) - $signed({sensor_x[POS_W-1], sensor_x});
				dy_s1  <= $signed({wy[POS_W-1], wy}) - $signed({sensor_y[POS_W-1], sensor_y});
				cdx_s2 <= rc_s1 * dx_s1;
				sdy_s2 <= rs_s1 * dy_s1;
				sdx_s2 <= rs_s1 * dx_s1;
				cdy_s2 <= rc_s1 * dy_s1;
			end
		end

		// floor by arithmetic shift, then clamp to the coordinate width
		always_comb begin
			sx = $signed({cdx_s2[PW-1], cdx_s2}) - $signed({sdy_s2[PW-1], sdy_s2});
			sy = $signed({sdx_s2[PW-1], sdx_s2}) + $signed({cdy_s2[PW-1], cdy_s2});
			fx = sx[SMW-1:FRAC_BITS];
			fy = sy[SMW-1:FRAC_BITS];
			ex = EW'(fx);
			ey = EW'(fy);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				loc_x_s3[i] <= (ex > CMAX) ? CMAX[COORD_BITS-1:0] :
					(ex < CMIN) ? CMIN[COORD_BITS-1:0] : ex[COORD_BITS-1:0];
				loc_y_s3[i] <= (ey > CMAX) ? CMAX[COORD_BITS-1:0] :
					(ey < CMIN) ? CMIN[COORD_BITS-1:0] : ey[COORD_BITS-1:0];
			end
		end
	end

endmodule

// ===== design/sqrc_edge.sv =====
// ----------------------------------------------------------------------------
// sqrc_edge
// Ray against one polygon edge: cross products, sign fix, pipelined divider.
// ----------------------------------------------------------------------------
module sqrc_edge #(
	parameter int COORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic signed [COORD_BITS-1:0]      p0x,
	input  logic signed [COORD_BITS-1:0]      p0y,
	input  logic signed [COORD_BITS-1:0]      p1x,
	input  logic signed [COORD_BITS-1:0]      p1y,
	input  logic signed [sqrc_pkg::DIR_W-1:0] dir_c,
	input  logic signed [sqrc_pkg::DIR_W-1:0] dir_s,
	output sqrc_pkg::sqrc_hit_t               res
);
	import sqrc_pkg::*;

	localparam int XW  = COORD_BITS + 1;
	localparam int AW  = XW + DIR_W;
	localparam int DNW = AW + 1;
	localparam int BW  = COORD_BITS + XW;
	localparam int TW  = BW + 1;
	localparam int CW  = COORD_BITS + DIR_W;
	localparam int UW  = CW + 1;
	localparam int RW0 = 2 * COORD_BITS + 19;
	localparam int RW1 = DNW + DIV_STEPS + 1;
	localparam int RW  = RW0 > RW1 ? RW0 : RW1;

	logic signed [XW-1:0]  ex, ey;
	logic signed [AW-1:0]  cey_s1, sex_s1;
	logic signed [BW-1:0]  pxey_s1, pyex_s1;
	logic signed [CW-1:0]  pxs_s1, pyc_s1;
	logic signed [DNW-1:0] den_s2;
	logic signed [TW-1:0]  tn_s2;
	logic signed [UW-1:0]  un_s2;

	logic                  neg;
	logic signed [DNW:0]   den_n;
	logic signed [TW:0]    tn_n;
	logic signed [UW:0]    un_n;
	logic [DNW-1:0]        dabs;
	logic [RW-1:0]         tn_w, dabs_w;
	logic                  ok_c;

	logic [RW-1:0]         rem_s  [DIV_STEPS+1];
	logic [DNW-1:0]        dmag_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0]  quo_s  [DIV_STEPS+1];
	logic                  ok_s   [DIV_STEPS+1];
	logic                  sat_s  [DIV_STEPS+1];

	assign ex = $signed({p1x[COORD_BITS-1], p1x}) - $signed({p0x[COORD_BITS-1], p0x});
	assign ey = $signed({p1y[COORD_BITS-1], p1y}) - $signed({p0y[COORD_BITS-1], p0y});

	always_ff @(posedge clk) begin
		if (en) begin
			cey_s1  <= dir_c * ey;
			sex_s1  <= dir_s * ex;
			pxey_s1 <= p0x * ey;
			pyex_s1 <= p0y * ex;
			pxs_s1  <= p0x * dir_s;
			pyc_s1  <= p0y * dir_c;
			den_s2  <= $signed({cey_s1[AW-1], cey_s1}) - $signed({sex_s1[AW-1], sex_s1});
			tn_s2   <= $signed({pxey_s1[BW-1], pxey_s1}) - $signed({pyex_s1[BW-1], pyex_s1});
			un_s2   <= $signed({pxs_s1[CW-1], pxs_s1}) - $signed({pyc_s1[CW-1], pyc_s1});
		end
	end

	// flip all signs when the denominator is negative
	always_comb begin
		neg    = den_s2[DNW-1];
		den_n  = neg ? -(DNW+1)'(den_s2) : (DNW+1)'(den_s2);
		tn_n   = neg ? -(TW+1)'(tn_s2) : (TW+1)'(tn_s2);
		un_n   = neg ? -(UW+1)'(un_s2) : (UW+1)'(un_s2);
		dabs   = den_n[DNW-1:0];
		tn_w   = RW'(tn_n[TW-1:0]);
		dabs_w = RW'(dabs);
		ok_c   = (dabs != '0) && !un_n[UW] && (RW'(un_n[UW-1:0]) <= dabs_w)
			&& !tn_n[TW] && (tn_n != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= tn_w << FRAC_BITS;
			dmag_s[0] <= dabs;
			quo_s[0]  <= '0;
			sat_s[0]  <= tn_w >= (dabs_w << FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s[0] <= 1'b0;
		end else if (en) begin
			ok_s[0] <= ok_c;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int B = DIV_STEPS - 1 - k;
		logic [RW-1:0] dd;
		logic          ge;

		assign dd = RW'(dmag_s[k]) << B;
		assign ge = rem_s[k] >= dd;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? rem_s[k] - dd : rem_s[k];
				dmag_s[k+1] <= dmag_s[k];
				quo_s[k+1]  <= quo_s[k] | (DIV_STEPS'(ge) << B);
				sat_s[k+1]  <= sat_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ok_s[k+1] <= 1'b0;
			end else if (en) begin
				ok_s[k+1] <= ok_s[k];
			end
		end
	end

	assign res.hit  = ok_s[DIV_STEPS];
	assign res.span = sat_s[DIV_STEPS] ? '1 : RANGE_W'(quo_s[DIV_STEPS]);

endmodule

// ===== design/scan_quad_ray_cast.sv =====
// A beam request passes the front stages, the edge units, the merge stage and the output register.
// Throughput: one request per cycle while the result side does not stall; pose and beam requests share the pipeline.
// A pose takes effect for every beam accepted after it.
// Stalls on the result side freeze the whole pipeline; nothing is lost.
// Reset clears corners, height, sensor-frame corners and injection (pass through).
// ----------------------------------------------------------------------------
// scan_quad_ray_cast
// Casts each scan beam against a virtual polygon and shortens its range.
// ----------------------------------------------------------------------------
`include "scan_quad_ray_cast_defines.svh"

module scan_quad_ray_cast #(
	parameter int NUM_CORNERS = 4,
	parameter int COORD_BITS  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [$clog2(NUM_CORNERS+1)-1:0]     cfg_index,
	input  logic [sqrc_pkg::CORNER_W-1:0]        cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// sensor_x, sensor_y, sensor_z, rot_cos, rot_sin, beam_cos, beam_sin, range_in
	input  logic [sqrc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// func
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// range_out
	output logic [sqrc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// replaced
	output logic                                 m_axis_tuser
);
	import sqrc_pkg::*;

	localparam int IDX_W = $clog2(NUM_CORNERS + 1);

	logic                      en;
	logic [CORNER_W-1:0]       corner_q [NUM_CORNERS];
	logic signed [POS_W-1:0]   height_q;
	logic signed [COORD_BITS-1:0] loc_x_q [NUM_CORNERS];
	logic signed [COORD_BITS-1:0] loc_y_q [NUM_CORNERS];
	logic                      inject_q;

	logic signed [COORD_BITS-1:0] px_s3 [NUM_CORNERS];
	logic signed [COORD_BITS-1:0] py_s3 [NUM_CORNERS];
	logic                      hok_s3;

	logic                      vp_s1, vp_s2, vp_s3;
	logic                      vb_s1, vb_s2, vb_s3;
	logic [DIR_W-1:0]          bc_s1, bc_s2, bc_s3;
	logic [DIR_W-1:0]          bs_s1, bs_s2, bs_s3;
	logic [RANGE_W-1:0]        rng_s1, rng_s2, rng_s3;

	logic                      vb_d  [EDGE_LAT];
	logic                      inj_d [EDGE_LAT];
	logic [RANGE_W-1:0]        rng_d [EDGE_LAT];

	sqrc_hit_t                 hits [NUM_CORNERS];
	logic                      found;
	logic [RANGE_W-1:0]        best;
	logic                      vb_m, found_m;
	logic [RANGE_W-1:0]        best_m, rng_m;
	logic                      out_valid_q, out_repl_q;
	logic [RANGE_W-1:0]        out_range_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// configuration registers
	for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_cfg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				corner_q[i] <= '0;
			end else if (cfg_we && cfg_index == IDX_W'(i)) begin
				corner_q[i] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= '0;
		end else if (cfg_we && cfg_index == IDX_W'(NUM_CORNERS)) begin
			height_q <= cfg_data[POS_W-1:0];
		end
	end

	// front stages: kind flags and beam payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_s1 <= 1'b0;
			vp_s2 <= 1'b0;
			vp_s3 <= 1'b0;
			vb_s1 <= 1'b0;
			vb_s2 <= 1'b0;
			vb_s3 <= 1'b0;
		end else if (en) begin
			vp_s1 <= s_axis_tvalid && (s_axis_tuser == FUNC_POSE);
			vb_s1 <= s_axis_tvalid && (s_axis_tuser == FUNC_BEAM);
			vp_s2 <= vp_s1;
			vb_s2 <= vb_s1;
			vp_s3 <= vp_s2;
			vb_s3 <= vb_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bc_s1  <= s_axis_tdata[BC_LO +: DIR_W];
			bs_s1  <= s_axis_tdata[BS_LO +: DIR_W];
			rng_s1 <= s_axis_tdata[RNG_LO +: RANGE_W];
			bc_s2  <= bc_s1;
			bs_s2  <= bs_s1;
			rng_s2 <= rng_s1;
			bc_s3  <= bc_s2;
			bs_s3  <= bs_s2;
			rng_s3 <= rng_s2;
		end
	end

	sqrc_pose #(
		.NUM_CORNERS (NUM_CORNERS),
		.COORD_BITS  (COORD_BITS)
	) u_pose (
		.clk          (clk),
		.en           (en),
		.corners      (corner_q),
		.obj_height   (height_q),
		.sensor_x     (s_axis_tdata[SX_LO +: POS_W]),
		.sensor_y     (s_axis_tdata[SY_LO +: POS_W]),
		.sensor_z     (s_axis_tdata[SZ_LO +: POS_W]),
		.rot_cos      (s_axis_tdata[RC_LO +: DIR_W]),
		.rot_sin      (s_axis_tdata[RS_LO +: DIR_W]),
		.loc_x_s3     (px_s3),
		.loc_y_s3     (py_s3),
		.height_ok_s3 (hok_s3)
	);

	// commit the pose; beams behind it read the new corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inject_q <= 1'b0;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				loc_x_q[i] <= '0;
				loc_y_q[i] <= '0;
			end
		end else if (en && vp_s3) begin
			inject_q <= hok_s3;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				loc_x_q[i] <= px_s3[i];
				loc_y_q[i] <= py_s3[i];
			end
		end
	end

	for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_edge
		localparam int J = (i + 1) % NUM_CORNERS;
		sqrc_edge #(
			.COORD_BITS (COORD_BITS)
		) u_edge (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.p0x    (loc_x_q[i]),
			.p0y    (loc_y_q[i]),
			.p1x    (loc_x_q[J]),
			.p1y    (loc_y_q[J]),
			.dir_c  (bc_s3),
			.dir_s  (bs_s3),
			.res    (hits[i])
		);
	end

	// beam side data alongside the edge units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < EDGE_LAT; k++) begin
				vb_d[k] <= 1'b0;
			end
		end else if (en) begin
			vb_d[0] <= vb_s3;
			for (int k = 1; k < EDGE_LAT; k++) begin
				vb_d[k] <= vb_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inj_d[0] <= inject_q;
			rng_d[0] <= rng_s3;
			for (int k = 1; k < EDGE_LAT; k++) begin
				inj_d[k] <= inj_d[k-1];
				rng_d[k] <= rng_d[k-1];
			end
		end
	end

	// nearest hit over the edges
	always_comb begin
		found = 1'b0;
		best  = '0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			if (hits[i].hit && (!found || hits[i].span < best)) begin
				found = 1'b1;
				best  = hits[i].span;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_m        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vb_m        <= vb_d[EDGE_LAT-1];
			out_valid_q <= vb_m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_m     <= found && inj_d[EDGE_LAT-1];
			best_m      <= best;
			rng_m       <= rng_d[EDGE_LAT-1];
			out_repl_q  <= found_m && (best_m < rng_m);
			out_range_q <= (found_m && (best_m < rng_m)) ? best_m : rng_m;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_range_q;
	assign m_axis_tuser  = out_repl_q;

	`SQRC_ASSERT(a_repl_short, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata != '1), "replaced range must be below no-return")
	`SQRC_ASSERT_NEXT(a_pose_commit, en && vp_s3, inject_q == $past(hok_s3), "pose height window not committed")
	`SQRC_ASSERT_NEXT(a_out_from_beam, en && !vb_m, !m_axis_tvalid, "result without a beam request")
	`SQRC_ASSERT_NEXT(a_stall_freeze, !en, vb_m == $past(vb_m), "pipeline moved during a stall")

endmodule
